>>> src/assert_macros.svh
// Assertion helpers used by the RTL in lru_key_cache.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, disabled while reset is asserted.
`define ASSERT_CLKED(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lkc_pkg.sv
package lkc_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef logic signed [KEY_W-1:0] key_t;

    // What a cell does with its stored key when the store is updated.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        logic     capture;
        cell_op_t op;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENCODE,
        S_UPDATE
    } state_t;

endpackage

>>> src/lkc_cell.sv
module lkc_cell
    import lkc_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       entry_valid,
    input  key_t       probe_key,
    input  key_t       load_key,
    input  key_t       neighbor_key,
    output key_t       key,
    output logic       match
);

    key_t key_reg;
    key_t key_next;
    logic match_reg;
    logic match_next;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = entry_valid && (key_reg == probe_key);
        end
    end

    always_comb
    begin
        case (ctrl.op)
            CELL_SHIFT: key_next = neighbor_key;
            CELL_LOAD:  key_next = load_key;
            default:    key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        match_reg <= match_next;
    end

    assign key   = key_reg;
    assign match = match_reg;

endmodule

>>> src/lkc_encode.sv
module lkc_encode
    import lkc_pkg::*;
#(
    parameter int N = 64
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [N-1:0]                        match_vec,
    output logic [((N > 1) ? $clog2(N) : 1)-1:0] pos,
    output logic                                hit
);

    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

    // Cells whose index has bit b set.
    function automatic logic [N-1:0] bit_mask(input int b);
        logic [N-1:0] m;
        m = '0;
        for (int i = 0; i < N; i++)
        begin
            m[i] = ((i >> b) & 1) == 1;
        end
        return m;
    endfunction

    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic             hit_reg;
    logic             hit_next;

    // At most one cell matches, so each index bit is an OR over its cells.
    for (genvar b = 0; b < IDX_W; b++)
    begin : g_bit
        assign pos_next[b] = |(match_vec & bit_mask(b));
    end

    assign hit_next = |match_vec;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
            hit_reg <= hit_next;
        end
    end

    assign pos = pos_reg;
    assign hit = hit_reg;

endmodule

>>> src/lru_key_cache.sv
// Fully associative key cache with least-recently-used replacement.
// Keys enter as 32-bit signed words on the s_axis channel; each accepted word
// yields exactly one result word on the m_axis channel, carrying a hit flag,
// an evicted flag and the evicted key (zero when nothing was evicted).
// The store is a row of cells ordered from least recent (cell 0) upward.
// An access runs in three steps: the cells compare the key in parallel, the
// match vector is encoded to a position, and the row then shifts toward
// cell 0 above that position while the new key is loaded at the top.
// The result is valid the cycle after the update; no new word is accepted before
// then, as each lookup depends on the row left by the previous one. The user
// writes the capacity register via cfg_we/cfg_wdata only while idle, which the
// block does not enforce. Zero acts as one and values above MAX_ENTRIES act as
// MAX_ENTRIES. Reset empties the cache and sets the capacity to 64; no clearing
// pass is needed since only cells below the occupancy count take part in compares.
// When the receiver stalls, the finished result waits in the output register and
// the next access holds in its update step until the word is taken.
module lru_key_cache
    import lkc_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // [31:0] key
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [0] hit, [1] evicted, [33:2] evicted_key, rest 0
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    `include "assert_macros.svh"

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

    state_t state_reg;
    state_t state_next;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    key_t             probe_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_hit_reg;
    logic             out_evicted_reg;
    key_t             out_ekey_reg;

    // FSM outputs.
    logic accept;
    logic capture;
    logic enc_en;
    logic upd_fire;

    key_t             key_vec   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [IDX_W-1:0] hit_pos;
    logic             hit;

    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] occ_cmp;
    logic             evict;
    logic             shift_en;
    logic [OCC_W-1:0] start_pos;
    logic [OCC_W-1:0] last_pos;

    // Next state.
    always_comb
    begin
        case (state_reg)
            S_IDLE:   state_next = s_axis_tvalid ? S_ENCODE : S_IDLE;
            S_ENCODE: state_next = S_UPDATE;
            S_UPDATE: state_next = (!out_valid_reg || m_axis_tready) ? S_IDLE : S_UPDATE;
            default:  state_next = S_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb
    begin
        s_axis_tready = 1'b0;
        enc_en        = 1'b0;
        upd_fire      = 1'b0;
        case (state_reg)
            S_IDLE:   s_axis_tready = 1'b1;
            S_ENCODE: enc_en = 1'b1;
            S_UPDATE: upd_fire = !out_valid_reg || m_axis_tready;
            default:  s_axis_tready = 1'b0;
        endcase
    end

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign capture = accept;

    // Capacity as actually applied: zero acts as one, large values saturate.
    always_comb
    begin
        cap_eff = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > MAX_CMP)
        begin
            cap_eff = MAX_CMP;
        end
    end

    assign occ_cmp   = CMP_W'(occ_reg);
    assign evict     = !hit && (occ_cmp >= cap_eff);
    // A hit or an eviction closes a gap and puts the key at the top used cell.
    assign shift_en  = hit || evict;
    assign start_pos = hit ? OCC_W'(hit_pos) : '0;
    assign last_pos  = occ_reg - OCC_W'(1);

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        key_t       neighbor;
        logic       entry_valid;

        if (i < MAX_ENTRIES - 1)
        begin : g_mid
            assign neighbor = key_vec[i+1];
        end
        else
        begin : g_top
            assign neighbor = '0;
        end

        assign entry_valid = OCC_W'(i) < occ_reg;

        always_comb
        begin
            ctrl.capture = capture;
            ctrl.op      = CELL_HOLD;
            if (upd_fire)
            begin
                if (shift_en)
                begin
                    if (OCC_W'(i) == last_pos)
                    begin
                        ctrl.op = CELL_LOAD;
                    end
                    else if ((OCC_W'(i) >= start_pos) && (OCC_W'(i) < last_pos))
                    begin
                        ctrl.op = CELL_SHIFT;
                    end
                end
                else if (OCC_W'(i) == occ_reg)
                begin
                    ctrl.op = CELL_LOAD;
                end
            end
        end

        lkc_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .entry_valid  (entry_valid),
            .probe_key    (key_t'(s_axis_tdata)),
            .load_key     (probe_reg),
            .neighbor_key (neighbor),
            .key          (key_vec[i]),
            .match        (match_vec[i])
        );
    end

    lkc_encode #(
        .N (MAX_ENTRIES)
    ) u_encode (
        .clk       (clk),
        .en        (enc_en),
        .match_vec (match_vec),
        .pos       (hit_pos),
        .hit       (hit)
    );

    always_comb
    begin
        capacity_next = cfg_we ? cfg_wdata : capacity_reg;
    end

    // Occupancy grows only when a miss finds room.
    always_comb
    begin
        occ_next = occ_reg;
        if (upd_fire && !shift_en)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            probe_reg <= key_t'(s_axis_tdata);
        end
        if (upd_fire)
        begin
            out_hit_reg     <= hit;
            out_evicted_reg <= evict;
            out_ekey_reg    <= evict ? key_vec[0] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_ekey_reg, out_evicted_reg, out_hit_reg};

    // Keys held are unique, so at most one cell can match.
    `ASSERT_CLKED(a_match_onehot, clk, rst_n,
        (state_reg != S_ENCODE) || $onehot0(match_vec), "more than one cell matched")
    `ASSERT_CLKED(a_occ_bound, clk, rst_n,
        occ_reg <= OCC_W'(MAX_ENTRIES), "occupancy above the number of cells")
    `ASSERT_NEXT(a_occ_grow, clk, rst_n, upd_fire && !shift_en,
        occ_reg == $past(occ_reg) + OCC_W'(1), "append did not grow occupancy")

endmodule

>>> sim/tb_lru_key_cache.sv
`timescale 1ns / 1ps

// Testbench for the LRU key cache. A row model of the recency order predicts
// one result word for every accepted key, and a receive process compares each
// result word against the oldest prediction.
module tb_lru_key_cache;
    import lkc_pkg::*;

    localparam int MAX_ENTRIES    = 64;
    // An access goes through compare, encode and update before its result
    // word is registered, so a handful of cycles covers anything in flight.
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_MAX       = 2 * MAX_ENTRIES + 1;
    localparam key_t KEY_MIN      = 32'sh8000_0000;
    localparam key_t KEY_MAX      = 32'sh7FFF_FFFF;

    // One result word as it is unpacked from m_axis_tdata.
    typedef struct {
        logic hit;
        logic evicted;
        key_t evicted_key;
    } cache_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;   // [31:0] key
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [39:0]      m_axis_tdata;   // [0] hit, [1] evicted, [33:2] evicted_key, rest 0
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    // Model of the block: keys ordered from least recent (index 0) upward.
    key_t             recency_row [MAX_ENTRIES];
    int               held_count;
    logic [CAP_W-1:0] capacity_reg;

    // Predicted result words that have not been seen on the output yet.
    cache_result_t    pending_results [$];

    // Idle percentages for each side. Each bump of the request count asks
    // the receive process for one long stall.
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               rx_hold_req = 0;
    int               rx_hold_seen = 0;
    int               rx_hold_left = 0;

    int               mismatch_count = 0;
    int               keys_sent;
    int               hit_count;
    int               evict_count;
    int               results_seen = 0;
    int               quiet_cycles = 0;

    lru_key_cache #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one access to the model and returns the word the block should
    // produce. A zero capacity acts as one and anything above the row size
    // saturates. When the capacity has been lowered below the number of held
    // keys, a miss still replaces only the single oldest key, so the count of
    // held keys never shrinks.
    function automatic cache_result_t lru_access(key_t key);
        cache_result_t res;
        int            limit;
        int            pos;
        limit = (capacity_reg == '0) ? 1 :
                (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
        pos = -1;
        res.hit = 1'b0;
        res.evicted = 1'b0;
        res.evicted_key = '0;
        for (int i = 0; i < held_count; i++)
        begin
            if (recency_row[i] == key)
            begin
                pos = i;
                break;
            end
        end
        if (pos >= 0)
        begin
            for (int i = pos; i < held_count - 1; i++)
                recency_row[i] = recency_row[i + 1];
            recency_row[held_count - 1] = key;
            res.hit = 1'b1;
        end
        else if (held_count >= limit)
        begin
            res.evicted = 1'b1;
            res.evicted_key = recency_row[0];
            for (int i = 0; i < held_count - 1; i++)
                recency_row[i] = recency_row[i + 1];
            recency_row[held_count - 1] = key;
        end
        else
        begin
            recency_row[held_count] = key;
            held_count++;
        end
        return res;
    endfunction

    // Offers one key, idling first at the current sender rate, and records
    // the prediction once the word has been accepted. Valid stays high on
    // return so that back-to-back words need no extra assignment.
    task automatic send_key(key_t key);
        cache_result_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = lru_access(key);
        pending_results.insert(pending_results.size(), res);
        keys_sent++;
        if (res.hit)
            hit_count++;
        if (res.evicted)
            evict_count++;
    endtask

    // Stops offering words and waits until every predicted word has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The capacity is only written while the block is idle.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        capacity_reg = value;
    endtask

    // Capacity zero behaves as a single entry: a repeat hits, anything new
    // pushes the one held key out. The cache is still empty here.
    task automatic test_capacity_zero();
        write_capacity(7'd0);
        send_key(KEY_MIN);
        send_key(KEY_MIN);
        send_key(KEY_MAX);
        send_key(KEY_MAX);
        send_key(32'sd0);
    endtask

    // Extreme keys through a three-entry cache, with hits that reorder the row
    // and evictions of keys of both signs.
    task automatic test_key_extremes();
        write_capacity(7'd3);
        send_key(-32'sd1);
        send_key(32'sd1);
        send_key(32'sd0);
        send_key(KEY_MIN);
        send_key(-32'sd1);
        send_key(32'sd0);
    endtask

    // Fill to six keys, then drop the capacity to two: misses replace only
    // the oldest key and the number of held keys stays at six.
    task automatic test_capacity_lowered();
        write_capacity(7'd6);
        send_key(32'sh5555_5555);
        send_key(32'shAAAA_AAAA);
        send_key(32'sh0F0F_0F0F);
        write_capacity(7'd2);
        send_key(32'shDEAD_BEEF);
        send_key(32'sh5555_5555);
        send_key(32'sh1234_5678);
    endtask

    // The largest register value must saturate to the row size; the random
    // phase at this setting later fills the whole row.
    task automatic test_capacity_above_max();
        write_capacity(7'd127);
        send_key(32'sh1234_5678);
        send_key(32'sh7654_3210);
        send_key(-32'sd1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the block fills up and stalls its input.
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_drained();
        rx_hold_req++;
        for (int i = 0; i < 16; i++)
            send_key($urandom_range(1) ? key_t'($urandom) : KEY_MAX - key_t'(i % 3));
        wait_drained();
    endtask

    // Random accesses at one capacity. Most keys come from a pool somewhat
    // larger than the capacity so that hits, refreshes and evictions mix;
    // the rest are fresh random keys over the whole 32-bit range.
    task automatic test_random_phase(logic [CAP_W-1:0] cap, int n_keys);
        key_t key_pool [POOL_MAX];
        int   limit;
        int   pool_size;
        write_capacity(cap);
        limit = (cap == '0) ? 1 : (cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap);
        pool_size = limit + $urandom_range(limit) + 1;
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = key_t'($urandom);
        for (int i = 0; i < n_keys; i++)
        begin
            if ($urandom_range(99) < 80)
                send_key(key_pool[$urandom_range(pool_size - 1)]);
            else
                send_key(key_t'($urandom));
        end
    endtask

    // Receive side: random back-pressure, the requested long stall, and the
    // comparison of each accepted word with the oldest prediction.
    always @(posedge clk)
    begin
        cache_result_t want;
        logic [5:0]    pad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            pad = m_axis_tdata[39:34];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: result word %h arrived with nothing pending",
                             m_axis_tdata);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_axis_tdata[0] !== want.hit || m_axis_tdata[1] !== want.evicted
                    || m_axis_tdata[33:2] !== want.evicted_key || pad !== '0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"ERROR: result %0d expected hit=%0d evicted=%0d ",
                                  "key=%h, got hit=%0d evicted=%0d key=%h pad=%h"},
                                 results_seen, want.hit, want.evicted, want.evicted_key,
                                 m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[33:2],
                                 pad);
                end
            end
        end
        if (rx_hold_req != rx_hold_seen)
        begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("lru_key_cache test failed");
            $finish;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps [9];
        int               leftover;
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        keys_sent      = 0;
        hit_count      = 0;
        evict_count    = 0;
        held_count     = 0;
        capacity_reg   = CAP_RESET;
        for (int i = 0; i < MAX_ENTRIES; i++)
            recency_row[i] = '0;
        phase_caps = '{7'd2, 7'd8, 7'd33, 7'd127, 7'd0, 7'd100, 7'd1, 7'd64, 7'd5};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks run with both sides idling now and then, save the output stall test.
        tx_idle_pct = 34;
        rx_idle_pct = 54;
        test_capacity_zero();
        test_key_extremes();
        test_capacity_lowered();
        test_capacity_above_max();
        test_output_stall();

        // The random phases move from a busy receiver to a busy sender and
        // end with both sides running flat out.
        for (int p = 0; p < 9; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct = 34;
                rx_idle_pct = 54;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 54;
                rx_idle_pct = 34;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            test_random_phase(phase_caps[p], 150);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        leftover = pending_results.size();
        if (leftover != 0)
            $display("ERROR: %0d predicted result words never arrived", leftover);

        $display("Covered %0d accesses: %0d hits, %0d evictions, %0d result words checked.",
                 keys_sent, hit_count, evict_count, results_seen);
        $display("Capacities ran from zero to 127, including writes below the held count.");
        if (mismatch_count == 0 && leftover == 0)
            $display("lru_key_cache test passed");
        else
            $display("lru_key_cache test failed");
        $finish;
    end

endmodule

>>> lru_key_cache.f
+incdir+src
src/lkc_pkg.sv
src/lkc_cell.sv
src/lkc_encode.sv
src/lru_key_cache.sv
sim/tb_lru_key_cache.sv
